>>> design/grid_maze_generator_unit_defines.svh
// Assertion macros used by the maze generator top-level design file
`ifndef GRID_MAZE_GENERATOR_UNIT_DEFINES_SVH
`define GRID_MAZE_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define GMG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define GMG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/gmg_pkg.sv
// Shared types, constants and a helper function of the maze generator
package gmg_pkg;

	localparam int RND_W      = 8;
	localparam int ROW_W      = 5;
	localparam int COL_W      = 7;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_PAD    = OUT_DATA_W - ROW_W - COL_W - 1;

	localparam logic CMD_START = 1'b0;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [ROW_W-1:0] ROWS_RST = 5'd10;
	localparam logic [COL_W-1:0] COLS_RST = 7'd39;

	typedef enum logic [1:0] {
		DIR_BELOW,
		DIR_ABOVE,
		DIR_RIGHT,
		DIR_LEFT
	} dir_t;

	typedef struct packed {
		logic [3:0]       mask;
		logic [2:0]       cnt;
		dir_t             dir;
		logic [ROW_W-1:0] wall_row;
		logic [COL_W-1:0] wall_col;
	} nbr_res_t;

	// base-4 digit sum, folded twice
	function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
		logic [3:0] s;
		logic [2:0] t;
		logic [1:0] r;
		s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {2'b00, v[7:6]};
		t = {1'b0, s[1:0]} + {1'b0, s[3:2]};
		case (t) inside
			3'd0, 3'd3, 3'd6: r = 2'd0;
			3'd1, 3'd4:       r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

endpackage

>>> design/gmg_ram.sv
// Generic single-write, single-read RAM with registered read data
module gmg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> design/gmg_nbr.sv
// Neighbour unit: open-neighbour mask, count, random pick and wall position
module gmg_nbr import gmg_pkg::*; #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 64,
	localparam int ROW_CW = $clog2(MAX_ROWS + 1),
	localparam int COL_CW = $clog2(MAX_COLS + 1)
) (
	input  logic [ROW_CW-1:0]   rows_lim,
	input  logic [COL_CW-1:0]   cols_lim,
	input  logic [ROW_CW-1:0]   cur_row,
	input  logic [COL_CW-1:0]   cur_col,
	input  logic [MAX_COLS-1:0] row_below,
	input  logic [MAX_COLS-1:0] row_above,
	input  logic [MAX_COLS-1:0] row_mid,
	input  logic [RND_W-1:0]    rnd,
	output nbr_res_t            res
);

	logic [MAX_COLS:0] below_x;
	logic [MAX_COLS:0] above_x;
	logic [MAX_COLS:0] right_x;
	logic [MAX_COLS:0] left_x;
	logic [ROW_CW:0]   row_p1;
	logic [COL_CW:0]   col_p1;
	logic [COL_CW-1:0] col_nx;
	logic              row_in;
	logic              col_in;
	logic [3:0]        mask;
	logic [2:0]        cnt;
	logic [1:0]        pick;
	logic [2:0]        seen;
	logic              found;
	dir_t              dir;
	logic [ROW_W-1:0]  row_base;
	logic [COL_W-1:0]  col_base;
	logic [ROW_W-1:0]  wall_row;
	logic [COL_W-1:0]  wall_col;

	assign below_x  = {1'b0, row_below};
	assign above_x  = {1'b0, row_above};
	assign right_x  = {1'b0, row_mid};
	assign left_x   = {row_mid, 1'b0};
	assign row_p1   = (ROW_CW+1)'(cur_row) + (ROW_CW+1)'(1);
	assign col_p1   = (COL_CW+1)'(cur_col) + (COL_CW+1)'(1);
	assign col_nx   = COL_CW'(col_p1);
	assign row_in   = cur_row < rows_lim;
	assign col_in   = cur_col < cols_lim;

	assign mask[0] = (row_p1 < (ROW_CW+1)'(rows_lim)) && col_in && below_x[cur_col];
	assign mask[1] = (cur_row != '0) && ((cur_row - ROW_CW'(1)) < rows_lim) && col_in
		&& above_x[cur_col];
	assign mask[2] = row_in && (col_p1 < (COL_CW+1)'(cols_lim)) && right_x[col_nx];
	assign mask[3] = row_in && (cur_col != '0) && ((cur_col - COL_CW'(1)) < cols_lim)
		&& left_x[cur_col];

	assign cnt = {2'b00, mask[0]} + {2'b00, mask[1]} + {2'b00, mask[2]} + {2'b00, mask[3]};

	always_comb begin
		case (cnt)
			3'd2:    pick = {1'b0, rnd[0]};
			3'd3:    pick = mod3(rnd);
			3'd4:    pick = rnd[1:0];
			default: pick = 2'd0;
		endcase
	end

	always_comb begin
		seen  = '0;
		found = 1'b0;
		dir   = DIR_BELOW;
		for (int k = 0; k < 4; k++) begin
			if (mask[k] && !found) begin
				if (seen == {1'b0, pick}) begin
					dir   = dir_t'(2'(k));
					found = 1'b1;
				end
				seen = seen + 3'd1;
			end
		end
	end

	assign row_base = ROW_W'({cur_row, 1'b0});
	assign col_base = COL_W'({cur_col, 1'b0});

	always_comb begin
		case (dir)
			DIR_BELOW: begin
				wall_row = row_base + ROW_W'(2);
				wall_col = col_base + COL_W'(1);
			end
			DIR_ABOVE: begin
				wall_row = row_base;
				wall_col = col_base + COL_W'(1);
			end
			DIR_RIGHT: begin
				wall_row = row_base + ROW_W'(1);
				wall_col = col_base + COL_W'(2);
			end
			default: begin
				wall_row = row_base + ROW_W'(1);
				wall_col = col_base;
			end
		endcase
	end

	assign res = '{mask: mask, cnt: cnt, dir: dir, wall_row: wall_row, wall_col: wall_col};

endmodule

>>> design/grid_maze_generator_unit.sv
// Hunt-and-kill maze generator: APB registers, sequencer, row map and neighbour unit
//
// Input beat (s_*): s_tuser is the command (start a new maze or take one step),
// s_tdata the random word used to choose among open neighbours.
// Output beat (m_*): one per input beat; m_tuser flags a removed wall, m_tdata
// carries its wall-bitmap row and column and the done flag.
// Registers rows_in_use (0x0) and cols_in_use (0x4) must be written over APB only
// while idle; the block itself does not enforce this. Each neighbour test runs a
// check state, three reads of the row map (rows below, above and own), a state for
// the last read data and an evaluate state. A step beat tests at least two cells
// while carving, more when the rescan hunts for a cell. The check state also wraps
// the scan past a column limit lowered mid-maze and makes the end-of-maze check; a
// step on a finished maze goes from it straight to the output. One beat is in work
// at a time and s_tready is low meanwhile; the next beat can be taken in the cycle
// after its result enters the output register.
// Reset marks every cell unvisited at once through per-row valid bits and
// restores the default registers, so no start beat is needed after reset.
// A stalled output beat is held in the output register; the next input beat is
// taken meanwhile and its result waits until that register frees.
`include "grid_maze_generator_unit_defines.svh"

module grid_maze_generator_unit import gmg_pkg::*; #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [RND_W-1:0]      s_tdata,  // [7:0] random_word
	input  logic                  s_tuser,  // [0] command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // [4:0] wall_row, [11:5] wall_col, [12] done_res
	output logic                  m_tuser,  // [0] opened
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int ROW_CW = $clog2(MAX_ROWS + 1);
	localparam int COL_CW = $clog2(MAX_COLS + 1);
	localparam int AW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADV,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_EVAL,
		ST_PICK,
		ST_OUT
	} state_t;

	state_t                  state_q;
	logic [ROW_W-1:0]        rows_q;
	logic [COL_W-1:0]        cols_q;
	logic [ROW_CW-1:0]       scan_row_q;
	logic [COL_CW-1:0]       scan_col_q;
	logic [ROW_CW-1:0]       walk_row_q;
	logic [COL_CW-1:0]       walk_col_q;
	logic                    walking_q;
	logic                    repeat_q;
	logic                    finished_q;
	logic                    post_q;
	logic [RND_W-1:0]        rnd_q;
	logic                    opened_q;
	logic [ROW_W-1:0]        wall_row_q;
	logic [COL_W-1:0]        wall_col_q;
	logic [MAX_COLS-1:0]     row_below_q;
	logic [MAX_COLS-1:0]     row_above_q;
	logic [MAX_COLS-1:0]     row_mid_q;
	logic [MAX_ROWS-1:0]     vld_q;
	logic [AW-1:0]           raddr_s1;
	logic                    m_tvalid_q;
	logic [OUT_DATA_W-1:0]   m_tdata_q;
	logic                    m_tuser_q;

	logic [ROW_CW-1:0]       lim_rows;
	logic [COL_CW-1:0]       lim_cols;
	logic [ROW_CW-1:0]       cur_row;
	logic [COL_CW-1:0]       cur_col;
	logic [ROW_CW:0]         row_p1;
	logic [COL_CW-1:0]       col_p1;
	logic [COL_CW-1:0]       col_m1;
	logic [COL_CW-1:0]       scan_col_p1;
	logic [AW-1:0]           addr_below;
	logic [AW-1:0]           addr_above;
	logic [AW-1:0]           addr_mid;
	logic [AW-1:0]           raddr;
	logic [MAX_COLS-1:0]     rdata;
	logic [MAX_COLS-1:0]     row_eff;
	logic [MAX_COLS-1:0]     col_bit;
	logic [MAX_COLS-1:0]     mid_mark;
	logic                    we;
	logic [AW-1:0]           waddr;
	logic [MAX_COLS-1:0]     wdata;
	logic                    in_beat;
	logic                    out_free;
	logic                    cfg_wr;
	nbr_res_t                nres;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RST;
			cols_q <= COLS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ROWS: rows_q <= pwdata[ROW_W-1:0];
				REG_COLS: cols_q <= pwdata[COL_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ROWS: prdata = 32'(rows_q);
			REG_COLS: prdata = 32'(cols_q);
		endcase
	end

	// bounds in use
	always_comb begin
		if (int'(rows_q) < MAX_ROWS) begin
			lim_rows = ROW_CW'(rows_q);
		end else begin
			lim_rows = ROW_CW'(MAX_ROWS);
		end
		if (int'(cols_q) < MAX_COLS) begin
			lim_cols = COL_CW'(cols_q);
		end else begin
			lim_cols = COL_CW'(MAX_COLS);
		end
	end

	assign cur_row     = walking_q ? walk_row_q : scan_row_q;
	assign cur_col     = walking_q ? walk_col_q : scan_col_q;
	assign row_p1      = (ROW_CW+1)'(cur_row) + (ROW_CW+1)'(1);
	assign col_p1      = cur_col + COL_CW'(1);
	assign col_m1      = cur_col - COL_CW'(1);
	assign scan_col_p1 = scan_col_q + COL_CW'(1);

	assign addr_below = (row_p1 < (ROW_CW+1)'(MAX_ROWS)) ? AW'(row_p1) : '0;
	assign addr_above = (cur_row != '0) ? AW'(cur_row - ROW_CW'(1)) : '0;
	assign addr_mid   = (cur_row < ROW_CW'(MAX_ROWS)) ? AW'(cur_row) : '0;

	always_comb begin
		unique case (state_q)
			ST_RD0:  raddr = addr_below;
			ST_RD1:  raddr = addr_above;
			default: raddr = addr_mid;
		endcase
	end

	// rows never written since reset or start read as all unvisited
	assign row_eff  = vld_q[raddr_s1] ? rdata : '1;
	assign col_bit  = MAX_COLS'(1) << cur_col;
	assign mid_mark = row_mid_q & ~col_bit;

	always_comb begin
		we    = 1'b0;
		waddr = addr_mid;
		wdata = mid_mark;
		if (state_q == ST_EVAL && !walking_q) begin
			we = 1'b1;
		end else if (state_q == ST_PICK) begin
			we = 1'b1;
			case (nres.dir)
				DIR_BELOW: begin
					waddr = addr_below;
					wdata = row_below_q & ~col_bit;
				end
				DIR_ABOVE: begin
					waddr = addr_above;
					wdata = row_above_q & ~col_bit;
				end
				DIR_RIGHT: begin
					wdata = row_mid_q & ~(MAX_COLS'(1) << col_p1);
				end
				default: begin
					wdata = row_mid_q & ~(MAX_COLS'(1) << col_m1);
				end
			endcase
		end
	end

	gmg_ram #(
		.WIDTH (MAX_COLS),
		.DEPTH (MAX_ROWS)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	gmg_nbr #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_nbr (
		.rows_lim  (lim_rows),
		.cols_lim  (lim_cols),
		.cur_row   (cur_row),
		.cur_col   (cur_col),
		.row_below (row_below_q),
		.row_above (row_above_q),
		.row_mid   (row_mid_q),
		.rnd       (rnd_q),
		.res       (nres)
	);

	assign in_beat  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_row_q  <= '0;
			scan_col_q  <= '0;
			walk_row_q  <= '0;
			walk_col_q  <= '0;
			walking_q   <= 1'b0;
			repeat_q    <= 1'b0;
			finished_q  <= 1'b0;
			post_q      <= 1'b0;
			rnd_q       <= '0;
			opened_q    <= 1'b0;
			wall_row_q  <= '0;
			wall_col_q  <= '0;
			row_below_q <= '0;
			row_above_q <= '0;
			row_mid_q   <= '0;
			vld_q       <= '0;
			raddr_s1    <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= 1'b0;
		end else begin
			raddr_s1 <= raddr;
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						rnd_q      <= s_tdata;
						opened_q   <= 1'b0;
						wall_row_q <= '0;
						wall_col_q <= '0;
						if (s_tuser == CMD_START) begin
							vld_q      <= '0;
							scan_row_q <= '0;
							scan_col_q <= '0;
							walk_row_q <= '0;
							walk_col_q <= '0;
							walking_q  <= 1'b0;
							repeat_q   <= 1'b0;
							finished_q <= 1'b0;
							post_q     <= 1'b1;
						end else begin
							post_q <= 1'b0;
						end
						state_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					if (finished_q) begin
						state_q <= ST_OUT;
					end else if (walking_q) begin
						state_q <= ST_RD0;
					end else if (scan_row_q >= lim_rows) begin
						finished_q <= 1'b1;
						state_q    <= ST_OUT;
					end else if (scan_col_q >= lim_cols) begin
						scan_col_q <= '0;
						scan_row_q <= scan_row_q + ROW_CW'(1);
					end else begin
						state_q <= ST_RD0;
					end
				end
				ST_RD0: begin
					state_q <= ST_RD1;
				end
				ST_RD1: begin
					row_below_q <= row_eff;
					state_q     <= ST_RD2;
				end
				ST_RD2: begin
					row_above_q <= row_eff;
					state_q     <= ST_RD3;
				end
				ST_RD3: begin
					row_mid_q <= row_eff;
					state_q   <= ST_EVAL;
				end
				ST_EVAL: begin
					if (!walking_q) begin
						row_mid_q <= mid_mark;
					end
					if (nres.cnt != 3'd0) begin
						state_q <= post_q ? ST_OUT : ST_PICK;
					end else begin
						if (!walking_q || !repeat_q) begin
							if (scan_col_p1 >= lim_cols) begin
								scan_col_q <= '0;
								scan_row_q <= scan_row_q + ROW_CW'(1);
							end else begin
								scan_col_q <= scan_col_p1;
							end
						end
						walking_q <= 1'b0;
						repeat_q  <= 1'b0;
						state_q   <= ST_ADV;
					end
				end
				ST_PICK: begin
					if (!walking_q) begin
						repeat_q <= (nres.cnt >= 3'd2);
					end
					opened_q   <= 1'b1;
					wall_row_q <= nres.wall_row;
					wall_col_q <= nres.wall_col;
					walking_q  <= 1'b1;
					post_q     <= 1'b1;
					case (nres.dir)
						DIR_BELOW: begin
							walk_row_q <= ROW_CW'(row_p1);
							walk_col_q <= cur_col;
						end
						DIR_ABOVE: begin
							walk_row_q <= cur_row - ROW_CW'(1);
							walk_col_q <= cur_col;
						end
						DIR_RIGHT: begin
							walk_row_q <= cur_row;
							walk_col_q <= col_p1;
						end
						default: begin
							walk_row_q <= cur_row;
							walk_col_q <= col_m1;
						end
					endcase
					state_q <= ST_ADV;
				end
				ST_OUT: begin
					if (out_free) begin
						m_tuser_q  <= opened_q;
						m_tdata_q  <= {{OUT_PAD{1'b0}}, finished_q, wall_col_q, wall_row_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`GMG_ASSERT_NXT(a_busy_after_beat, in_beat, !s_tready, "input beat taken while busy")
	`GMG_ASSERT_IMP(a_repeat_in_walk, repeat_q, walking_q, "rescan mark set outside a walk")
	`GMG_ASSERT_NXT(a_finished_sticky, finished_q && !(in_beat && s_tuser == CMD_START),
		finished_q, "finished cleared without a start beat")
	`GMG_ASSERT_NXT(a_out_wait, state_q == ST_OUT && m_tvalid && !m_tready,
		state_q == ST_OUT && m_tvalid, "result overwrote a stalled output beat")

endmodule
